// ----- rtl/bcdt_pkg.sv -----
// Shared constants, types and word layouts of the BCD countdown and tracking timer.
package bcdt_pkg;

	localparam int TICKS_PER_STEP  = 10;
	localparam int STEPS_PER_COUNT = 10;
	localparam int BLINK_END       = 50;
	localparam int TRACK_DIGITS    = 5;
	localparam int CD_DIGITS       = 6;
	localparam int PACK_W          = 32;

	localparam int TICK_W  = $clog2(TICKS_PER_STEP + 1);
	localparam int STEP_W  = $clog2(STEPS_PER_COUNT + 1);
	localparam int BLINK_W = $clog2(BLINK_END + 1);

	typedef logic [TICK_W-1:0]  tick_t;
	typedef logic [STEP_W-1:0]  step_t;
	typedef logic [BLINK_W-1:0] blink_t;
	typedef logic [3:0]         digit_t;
	typedef logic [1:0]         func_t;

	localparam func_t FUNC_TICK  = 2'd0;
	localparam func_t FUNC_LOAD  = 2'd1;
	localparam func_t FUNC_BLINK = 2'd2;
	localparam func_t FUNC_CLEAR = 2'd3;

	localparam digit_t BLANK_CODE  = 4'd15;
	localparam digit_t PHASE_LAST  = 4'd9;
	localparam digit_t PHASE_BLANK = 4'd5;
	localparam digit_t PHASE_SHOW  = 4'd0;
	localparam digit_t TRACK_MAX   = 4'd9;

	localparam digit_t WRAP_VALUE [CD_DIGITS] = '{4'd0, 4'd9, 4'd5, 4'd9, 4'd5, 4'd9};

	typedef struct packed {
		func_t       func;
		logic        mode;
		logic        running;
		logic [2:0]  edit_digit;
		logic [3:0]  edit_value;
		logic [15:0] power_sample;
		logic [23:0] load_time;
	} in_word_t;

	typedef struct packed {
		logic [3:0]  hours_tens;
		logic [3:0]  hours_ones;
		logic [3:0]  minutes_tens;
		logic [3:0]  minutes_ones;
		logic [2:0]  seconds_tens;
		logic [3:0]  seconds_ones;
		logic [19:0] tracking_time;
		logic [15:0] shown_power;
		logic [31:0] energy_total;
	} out_word_t;

endpackage

// ----- rtl/bcdt_if.sv -----
// Valid/ready channel interfaces for the input and result words.
interface bcdt_in_if;
	logic               valid;
	logic               ready;
	bcdt_pkg::in_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface bcdt_out_if;
	logic                valid;
	logic                ready;
	bcdt_pkg::out_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/bcd_countdown_and_tracking_timer_top.sv -----
// Top level of the BCD countdown and tracking timer: input register, core and result register.
//
// Channel  Direction  Word        Fields
// item     in         in_word_t   func, mode, running, edit_digit, edit_value, power_sample,
//                                 load_time
// result   out        out_word_t  six countdown digits, tracking_time, shown_power,
//                                 energy_total
//
// Each word passes from acceptance through the input register, then through the core update
// into the result register. A new word is accepted every cycle unless both registers are full
// and the result is stalled. The core state advances once per word, so throughput is set by
// the result register alone. Reset clears the timer state at once; there is no clearing pass.
// A stalled result holds both registers; item.ready drops only when both are full.
module bcd_countdown_and_tracking_timer_top (
	input  logic              clk,
	input  logic              arst_n,
	bcdt_in_if.sink           item,
	bcdt_out_if.source        result
);

	logic                valid_s1;
	bcdt_pkg::in_word_t  data_s1;
	logic                valid_s2;
	bcdt_pkg::out_word_t data_s2;
	bcdt_pkg::out_word_t view;
	logic                adv;

	assign adv        = valid_s1 && (!valid_s2 || result.ready);
	assign item.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			data_s1 <= item.data;
		end
	end

	bcdt_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.word   (data_s1),
		.view   (view)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_s2 <= view;
		end
	end

	assign result.valid = valid_s2;
	assign result.data  = data_s2;

	a_adv_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> result.valid)
		else $error("A processed word did not reach the result register.");

	a_ready_low_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!item.ready |-> (valid_s1 && result.valid && !result.ready))
		else $error("Input stalled while a register was free.");

	a_no_lost_result: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.ready) |=> result.valid)
		else $error("A pending result was dropped.");

endmodule

// ----- rtl/bcdt_core.sv -----
// Timer state registers and the single-pass update for one input word.
module bcdt_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  bcdt_pkg::in_word_t  word,
	output bcdt_pkg::out_word_t view
);

	bcdt_pkg::tick_t  tick_q, tick_n;
	bcdt_pkg::step_t  step_q, step_n;
	bcdt_pkg::blink_t blink_q, blink_n;
	bcdt_pkg::digit_t phase_q, phase_n;
	bcdt_pkg::digit_t cd_q [bcdt_pkg::CD_DIGITS];
	bcdt_pkg::digit_t cd_n [bcdt_pkg::CD_DIGITS];
	bcdt_pkg::digit_t cd_b [bcdt_pkg::CD_DIGITS];
	bcdt_pkg::digit_t tr_q [bcdt_pkg::TRACK_DIGITS];
	bcdt_pkg::digit_t tr_n [bcdt_pkg::TRACK_DIGITS];
	logic [31:0] energy_q, energy_n;
	logic [15:0] power_q, power_n;
	logic [bcdt_pkg::PACK_W-1:0] packed_tr;

	always_comb begin
		logic       fire;
		logic       nz_hi;
		logic       nz_lo;
		logic       nz_all;
		logic       carry;
		logic [2:0] idx;

		tick_n   = tick_q;
		step_n   = step_q;
		blink_n  = blink_q;
		phase_n  = phase_q;
		cd_n     = cd_q;
		cd_b     = cd_q;
		tr_n     = tr_q;
		energy_n = energy_q;
		power_n  = power_q;
		fire     = 1'b0;
		nz_hi    = 1'b0;
		nz_lo    = 1'b0;
		nz_all   = 1'b0;
		carry    = 1'b1;
		idx      = 3'd0;

		case (word.func)
			bcdt_pkg::FUNC_LOAD: begin
				for (int i = 0; i < bcdt_pkg::CD_DIGITS; i++) begin
					cd_n[i] = word.load_time[(bcdt_pkg::CD_DIGITS - 1 - i) * 4 +: 4];
				end
			end
			bcdt_pkg::FUNC_BLINK: begin
				blink_n = '0;
				phase_n = '0;
			end
			bcdt_pkg::FUNC_CLEAR: begin
				for (int i = 0; i < bcdt_pkg::TRACK_DIGITS; i++) begin
					tr_n[i] = '0;
				end
				energy_n = '0;
			end
			default: begin
				fire = (tick_q == bcdt_pkg::tick_t'(bcdt_pkg::TICKS_PER_STEP - 1));
				tick_n = fire ? '0 : bcdt_pkg::tick_t'(tick_q + 1'b1);
				if (fire) begin
					if (blink_q != bcdt_pkg::blink_t'(bcdt_pkg::BLINK_END)) begin
						blink_n = bcdt_pkg::blink_t'(blink_q + 1'b1);
						phase_n = (phase_q == bcdt_pkg::PHASE_LAST) ? '0 : phase_q + 4'd1;
						if (word.edit_digit inside {[3'd1:3'd4]}) begin
							idx = word.edit_digit - 3'd1;
							if (phase_n == bcdt_pkg::PHASE_BLANK) begin
								cd_n[idx] = bcdt_pkg::BLANK_CODE;
							end else if (phase_n == bcdt_pkg::PHASE_SHOW) begin
								cd_n[idx] = word.edit_value;
							end
						end
					end
					if (!word.mode && word.running) begin
						if (step_q == bcdt_pkg::step_t'(bcdt_pkg::STEPS_PER_COUNT - 1)) begin
							step_n = '0;
							cd_b = cd_n;
							for (int i = 0; i < bcdt_pkg::CD_DIGITS; i++) begin
								nz_hi = 1'b0;
								nz_lo = 1'b0;
								for (int j = 0; j < bcdt_pkg::CD_DIGITS; j++) begin
									if (j > i && cd_b[j] != '0) nz_hi = 1'b1;
									if (j < i && cd_b[j] != '0) nz_lo = 1'b1;
								end
								if (cd_b[i] != bcdt_pkg::BLANK_CODE && !nz_hi) begin
									if (cd_b[i] != '0) begin
										cd_n[i] = cd_b[i] - 4'd1;
									end else if (nz_lo) begin
										cd_n[i] = bcdt_pkg::WRAP_VALUE[i];
									end
								end
							end
							for (int i = 0; i < bcdt_pkg::CD_DIGITS; i++) begin
								if (cd_n[i] != '0) nz_all = 1'b1;
							end
							if (nz_all) begin
								power_n  = word.power_sample;
								energy_n = energy_q + 32'(word.power_sample);
							end
						end else begin
							step_n = bcdt_pkg::step_t'(step_q + 1'b1);
						end
					end else if (word.mode) begin
						for (int i = 0; i < bcdt_pkg::TRACK_DIGITS; i++) begin
							if (carry) begin
								if (tr_q[i] >= bcdt_pkg::TRACK_MAX) begin
									tr_n[i] = '0;
								end else begin
									tr_n[i] = tr_q[i] + 4'd1;
									carry = 1'b0;
								end
							end
						end
					end
				end
			end
		endcase
	end

	always_comb begin
		packed_tr = '0;
		for (int i = 0; i < bcdt_pkg::TRACK_DIGITS; i++) begin
			packed_tr[4 * i +: 4] = tr_n[i];
		end
		view.hours_tens    = cd_n[0];
		view.hours_ones    = cd_n[1];
		view.minutes_tens  = cd_n[2];
		view.minutes_ones  = cd_n[3];
		view.seconds_tens  = cd_n[4][2:0];
		view.seconds_ones  = cd_n[5];
		view.tracking_time = packed_tr[19:0];
		view.shown_power   = power_n;
		view.energy_total  = energy_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q   <= '0;
			step_q   <= '0;
			blink_q  <= bcdt_pkg::blink_t'(bcdt_pkg::BLINK_END);
			phase_q  <= '0;
			energy_q <= '0;
			power_q  <= '0;
			for (int i = 0; i < bcdt_pkg::CD_DIGITS; i++) cd_q[i] <= '0;
			for (int i = 0; i < bcdt_pkg::TRACK_DIGITS; i++) tr_q[i] <= '0;
		end else if (en) begin
			tick_q   <= tick_n;
			step_q   <= step_n;
			blink_q  <= blink_n;
			phase_q  <= phase_n;
			energy_q <= energy_n;
			power_q  <= power_n;
			cd_q     <= cd_n;
			tr_q     <= tr_n;
		end
	end

endmodule
